@@ rtl/core/idpc_pkg.sv @@
// ----------------------------------------------------------------------------
// idpc_pkg
// Shared types, sizes and codes of the implant/decay pixel correlator.
// ----------------------------------------------------------------------------
package idpc_pkg;

    // detector geometry
    localparam int STRIPS  = 32;
    localparam int NPIX    = STRIPS * STRIPS;
    localparam int PIX_W   = $clog2(NPIX);
    localparam int STRIP_W = 6;

    // field widths
    localparam int TIME_W    = 48;
    localparam int DELAY_W   = TIME_W + 1;
    localparam int COND_W    = 3;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_IMPLANT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DECAY   = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IMPLANT_GAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRELATION_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_JUMP         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW_TIME     = 2'd3;

    // configuration reset values
    localparam logic [TIME_W-1:0] MIN_IMPLANT_GAP_RST    = 48'd500000;
    localparam logic [TIME_W-1:0] CORRELATION_WINDOW_RST = 48'd6000000000;
    localparam logic [TIME_W-1:0] RESET_JUMP_RST         = 48'd500000000000;
    localparam logic [TIME_W-1:0] RESET_LOW_TIME_RST     = 48'd1000000000;

    // result conditions
    typedef enum logic [COND_W-1:0] {
        COND_VALID_IMPLANT = 3'd0,
        COND_BACK_TO_BACK  = 3'd1,
        COND_VALID_DECAY   = 3'd2,
        COND_TOO_LATE      = 3'd3,
        COND_TOO_SOON      = 3'd4,
        COND_UNKNOWN       = 3'd5,
        COND_BAD_LOCATION  = 3'd6
    } cond_t;

    // one pixel record
    typedef struct packed {
        logic              implanted;
        logic [TIME_W-1:0] itime;
        logic [TIME_W-1:0] igap;
    } pix_entry_t;

    localparam pix_entry_t PIX_CLEAR = '{implanted: 1'b0, itime: '0, igap: '1};

    // pixel memory write port
    typedef struct packed {
        logic             en;
        logic [PIX_W-1:0] addr;
        pix_entry_t       data;
    } pix_wr_t;

    // pixel memory read request
    typedef struct packed {
        logic             en;
        logic [PIX_W-1:0] addr;
    } pix_rd_t;

endpackage

@@ rtl/core/idpc_pixel_ram.sv @@
// ----------------------------------------------------------------------------
// idpc_pixel_ram
// Pixel record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module idpc_pixel_ram (
    input  logic                   clk,
    input  idpc_pkg::pix_wr_t      wr,
    input  idpc_pkg::pix_rd_t      rd,
    output idpc_pkg::pix_entry_t   rd_data
);
    import idpc_pkg::*;

    pix_entry_t mem [NPIX];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

@@ rtl/core/implant_decay_pixel_correlator.sv @@
// ----------------------------------------------------------------------------
// implant_decay_pixel_correlator
// Per-pixel implant/decay correlation for a front-by-back strip detector.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid / in_stall   | event_kind, front_strip,
//           |           |                       | back_strip, timestamp
//   out     | output    | out_valid / out_stall | condition, decay_delay,
//           |           |                       | implant_gap, gap_any_implant,
//           |           |                       | clock_reset_seen
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// An event is handled in two steps: its pixel record is read from the memory,
// then the event is judged and, for an implant in range, the record is written back.
// A decay that flags a clock reset adds a sweep over the pixel memory,
// one entry read per cycle and cleared if its implant time is after the decay.
// After reset the memory is cleared entry by entry while in_stall is high.
// A stalled result waits in the output register; the judge cycle holds
// until that register frees up.
// ----------------------------------------------------------------------------
module implant_decay_pixel_correlator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // event input
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [idpc_pkg::KIND_W-1:0]            event_kind,
    input  logic [idpc_pkg::STRIP_W-1:0]           front_strip,
    input  logic [idpc_pkg::STRIP_W-1:0]           back_strip,
    input  logic [idpc_pkg::TIME_W-1:0]            timestamp,
    // result output
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [idpc_pkg::COND_W-1:0]            condition,
    output logic signed [idpc_pkg::DELAY_W-1:0]    decay_delay,
    output logic [idpc_pkg::TIME_W-1:0]            implant_gap,
    output logic [idpc_pkg::TIME_W-1:0]            gap_any_implant,
    output logic                                   clock_reset_seen,
    // configuration
    input  logic                                   cfg_we,
    input  logic [idpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [idpc_pkg::TIME_W-1:0]            cfg_data
);
    import idpc_pkg::*;

    localparam logic [STRIP_W:0]   STRIP_LIM = (STRIP_W + 1)'(STRIPS);
    localparam logic [PIX_W-1:0]   PIX_LAST  = PIX_W'(NPIX - 1);
    localparam logic [PIX_W-1:0]   PIX_ROW   = PIX_W'(STRIPS);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_SWEND = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [TIME_W-1:0] min_gap_reg, win_reg, jump_reg, low_time_reg;

    // global implant tracking
    logic [TIME_W-1:0] last_implant_reg;
    logic              any_seen_reg;

    // captured event
    logic [KIND_W-1:0] kind_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              loc_ok_reg;
    logic [TIME_W-1:0] ts_reg;

    // sweep / clear counter
    logic [PIX_W-1:0]  cnt_reg, cnt_next;
    logic [PIX_W-1:0]  sweep_wr_reg;
    logic              sweep_pend_reg;

    // output register
    logic               out_valid_reg;
    cond_t              cond_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TIME_W-1:0]  gap_reg, gap_any_reg;
    logic               rst_seen_reg;

    // memory ports
    pix_wr_t    wr;
    pix_rd_t    rd;
    pix_entry_t ent;

    // incoming event decode
    logic              accept;
    logic              loc_ok_in;
    logic [PIX_W-1:0]  pix_in;

    // judge results
    cond_t              res_cond;
    logic [DELAY_W-1:0] res_delay;
    logic [TIME_W-1:0]  res_gap, res_gap_any;
    logic               res_rst;
    logic               res_write;
    logic [TIME_W-1:0]  fwd_diff, back_diff, any_diff;
    logic               behind, in_window;
    logic               out_free, eval_go, sweep_hit;

    idpc_pixel_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (ent)
    );

    // input handshake and pixel address
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign loc_ok_in = ({1'b0, front_strip} < STRIP_LIM) && ({1'b0, back_strip} < STRIP_LIM);
    assign pix_in    = PIX_W'(front_strip) * PIX_ROW + PIX_W'(back_strip);

    assign out_free = !out_valid_reg || !out_stall;
    assign eval_go  = (state_reg == S_EVAL) && out_free;

    // judge the event against the pixel record
    always_comb
    begin
        fwd_diff    = ts_reg - ent.itime;
        back_diff   = ent.itime - ts_reg;
        any_diff    = ts_reg - last_implant_reg;
        behind      = ts_reg < ent.itime;
        in_window   = behind || (fwd_diff < win_reg);
        res_cond    = COND_UNKNOWN;
        res_delay   = '0;
        res_gap     = '1;
        res_gap_any = '1;
        res_rst     = 1'b0;
        res_write   = 1'b0;
        if (!loc_ok_reg)
        begin
            res_cond = COND_BAD_LOCATION;
        end
        else if (kind_reg == KIND_IMPLANT)
        begin
            res_write = 1'b1;
            if (any_seen_reg)
            begin
                res_gap_any = (ts_reg >= last_implant_reg) ? any_diff : '0;
            end
            if (ent.implanted)
            begin
                res_cond = COND_BACK_TO_BACK;
                res_gap  = behind ? '0 : fwd_diff;
            end
            else
            begin
                res_cond = COND_VALID_IMPLANT;
            end
        end
        else if (kind_reg == KIND_DECAY && ent.implanted)
        begin
            res_rst = behind && (back_diff > jump_reg) && (ts_reg < low_time_reg);
            res_gap = ent.igap;
            if (ent.igap >= min_gap_reg)
            begin
                if (in_window)
                begin
                    res_cond  = COND_VALID_DECAY;
                    res_delay = {1'b0, ts_reg} - {1'b0, ent.itime};
                end
                else
                begin
                    res_cond = COND_TOO_LATE;
                end
            end
            else
            begin
                res_cond = COND_TOO_SOON;
            end
        end
    end

    // memory read requests
    always_comb
    begin
        rd.en   = 1'b0;
        rd.addr = pix_in;
        case (state_reg)
            S_IDLE:
            begin
                rd.en = in_valid && loc_ok_in;
            end
            S_SWEEP:
            begin
                rd.en   = 1'b1;
                rd.addr = cnt_reg;
            end
            default:
            begin
                rd.en = 1'b0;
            end
        endcase
    end

    // memory writes: clearing pass, implant update, sweep clear
    assign sweep_hit = sweep_pend_reg && (ent.itime > ts_reg);

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = pix_reg;
        wr.data = PIX_CLEAR;
        case (state_reg)
            S_INIT:
            begin
                wr.en   = 1'b1;
                wr.addr = cnt_reg;
            end
            S_EVAL:
            begin
                wr.en   = eval_go && res_write;
                wr.data = '{implanted: 1'b1, itime: ts_reg, igap: res_gap};
            end
            S_SWEEP, S_SWEND:
            begin
                wr.en   = sweep_hit;
                wr.addr = sweep_wr_reg;
            end
            default:
            begin
                wr.en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_INIT:
            begin
                cnt_next = cnt_reg + PIX_W'(1);
                if (cnt_reg == PIX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cnt_next = '0;
                if (eval_go)
                begin
                    state_next = res_rst ? S_SWEEP : S_IDLE;
                end
            end
            S_SWEEP:
            begin
                cnt_next = cnt_reg + PIX_W'(1);
                if (cnt_reg == PIX_LAST)
                begin
                    state_next = S_SWEND;
                end
            end
            S_SWEND:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            cnt_reg          <= '0;
            sweep_pend_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            any_seen_reg     <= 1'b0;
            last_implant_reg <= '0;
            min_gap_reg      <= MIN_IMPLANT_GAP_RST;
            win_reg          <= CORRELATION_WINDOW_RST;
            jump_reg         <= RESET_JUMP_RST;
            low_time_reg     <= RESET_LOW_TIME_RST;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            sweep_pend_reg <= (state_reg == S_SWEEP);
            if (eval_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (eval_go && res_write)
            begin
                last_implant_reg <= ts_reg;
                any_seen_reg     <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_IMPLANT_GAP:    min_gap_reg  <= cfg_data;
                    CFG_CORRELATION_WINDOW: win_reg      <= cfg_data;
                    CFG_RESET_JUMP:         jump_reg     <= cfg_data;
                    CFG_RESET_LOW_TIME:     low_time_reg <= cfg_data;
                    default:                min_gap_reg  <= min_gap_reg;
                endcase
            end
        end
    end

    // event capture, sweep address and result payload
    always_ff @(posedge clk)
    begin
        sweep_wr_reg <= cnt_reg;
        if (accept)
        begin
            kind_reg   <= event_kind;
            pix_reg    <= pix_in;
            loc_ok_reg <= loc_ok_in;
            ts_reg     <= timestamp;
        end
        if (eval_go)
        begin
            cond_reg     <= res_cond;
            delay_reg    <= res_delay;
            gap_reg      <= res_gap;
            gap_any_reg  <= res_gap_any;
            rst_seen_reg <= res_rst;
        end
    end

    // result ports
    assign out_valid        = out_valid_reg;
    assign condition        = cond_reg;
    assign decay_delay      = signed'(delay_reg);
    assign implant_gap      = gap_reg;
    assign gap_any_implant  = gap_any_reg;
    assign clock_reset_seen = rst_seen_reg;

endmodule

@@ rtl/core/idpc_checker.sv @@
// ----------------------------------------------------------------------------
// idpc_checker
// Port-level checks of the implant/decay pixel correlator.
// ----------------------------------------------------------------------------
module idpc_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic [idpc_pkg::KIND_W-1:0]            event_kind,
    input  logic [idpc_pkg::STRIP_W-1:0]           front_strip,
    input  logic [idpc_pkg::STRIP_W-1:0]           back_strip,
    input  logic [idpc_pkg::TIME_W-1:0]            timestamp,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [idpc_pkg::COND_W-1:0]            condition,
    input  logic signed [idpc_pkg::DELAY_W-1:0]    decay_delay,
    input  logic [idpc_pkg::TIME_W-1:0]            implant_gap,
    input  logic [idpc_pkg::TIME_W-1:0]            gap_any_implant,
    input  logic                                   clock_reset_seen,
    input  logic                                   cfg_we,
    input  logic [idpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [idpc_pkg::TIME_W-1:0]            cfg_data
);
    import idpc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(condition) && $stable(decay_delay))
        else $error("stalled result changed");

    // an input transfer blocks the next cycle's transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second event taken while judging");

    // only a valid decay carries a delay
    a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && condition != COND_VALID_DECAY |-> decay_delay == '0)
        else $error("delay set outside a valid decay");

    // rejected events carry no gaps and no clock reset
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (condition == COND_UNKNOWN || condition == COND_BAD_LOCATION)
        |-> (&implant_gap) && (&gap_any_implant) && !clock_reset_seen)
        else $error("rejected event carries data");

    // a clock reset always sits inside the window
    a_reset_cond: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clock_reset_seen
        |-> condition == COND_VALID_DECAY || condition == COND_TOO_SOON)
        else $error("clock reset with a bad condition");

endmodule

bind implant_decay_pixel_correlator idpc_checker u_idpc_checker (.*);

@@ tb/sv/idpc_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpc_result_checker
// Watches the event, result and configuration ports of the pixel
// correlator. Keeps its own copy of the pixel records and registers, works
// out the result of every accepted event and compares each result transfer,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module idpc_result_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic [idpc_pkg::KIND_W-1:0]            event_kind,
    input  logic [idpc_pkg::STRIP_W-1:0]           front_strip,
    input  logic [idpc_pkg::STRIP_W-1:0]           back_strip,
    input  logic [idpc_pkg::TIME_W-1:0]            timestamp,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [idpc_pkg::COND_W-1:0]            condition,
    input  logic signed [idpc_pkg::DELAY_W-1:0]    decay_delay,
    input  logic [idpc_pkg::TIME_W-1:0]            implant_gap,
    input  logic [idpc_pkg::TIME_W-1:0]            gap_any_implant,
    input  logic                                   clock_reset_seen,
    input  logic                                   cfg_we,
    input  logic [idpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [idpc_pkg::TIME_W-1:0]            cfg_data,
    output int                                     mismatch_count,
    output int                                     results_due
);
    import idpc_pkg::*;

    typedef struct packed {
        cond_t              condition;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  gap;
        logic [TIME_W-1:0]  gap_any;
        logic               reset_seen;
    } verdict_t;

    // predicted pixel records
    logic              pix_implanted [NPIX];
    logic [TIME_W-1:0] pix_time      [NPIX];
    logic [TIME_W-1:0] pix_gap       [NPIX];
    logic [TIME_W-1:0] last_time;
    logic              any_seen;

    // predicted registers
    logic [TIME_W-1:0] min_gap_reg;
    logic [TIME_W-1:0] window_reg;
    logic [TIME_W-1:0] jump_reg;
    logic [TIME_W-1:0] low_time_reg;

    verdict_t pending_verdicts [$];

    // append a prediction behind the outstanding ones
    function automatic void enqueue_verdict(input verdict_t v);
        pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    // difference that floors at zero when time runs backward
    function automatic logic [TIME_W-1:0] gap_floor(input logic [TIME_W-1:0] newer,
                                                    input logic [TIME_W-1:0] older);
        return (newer >= older) ? newer - older : '0;
    endfunction

    // judge one event and update the pixel records
    task automatic judge_event(input logic [KIND_W-1:0] kind,
                               input logic [STRIP_W-1:0] fs,
                               input logic [STRIP_W-1:0] bs,
                               input logic [TIME_W-1:0] ts,
                               output verdict_t v);
        int unsigned       p;
        logic [TIME_W-1:0] it;
        logic [TIME_W-1:0] ig;
        logic              in_window;
        v.condition  = COND_UNKNOWN;
        v.delay      = '0;
        v.gap        = '1;
        v.gap_any    = '1;
        v.reset_seen = 1'b0;
        if (fs >= STRIPS || bs >= STRIPS)
        begin
            v.condition = COND_BAD_LOCATION;
        end
        else
        begin
            p = fs * STRIPS + bs;
            if (kind == KIND_IMPLANT)
            begin
                if (any_seen)
                    v.gap_any = gap_floor(ts, last_time);
                if (pix_implanted[p])
                begin
                    v.condition = COND_BACK_TO_BACK;
                    pix_gap[p] = gap_floor(ts, pix_time[p]);
                end
                else
                begin
                    v.condition = COND_VALID_IMPLANT;
                    pix_implanted[p] = 1'b1;
                    pix_gap[p] = '1;
                end
                v.gap = pix_gap[p];
                pix_time[p] = ts;
                last_time = ts;
                any_seen = 1'b1;
            end
            else if (kind == KIND_DECAY && pix_implanted[p])
            begin
                it = pix_time[p];
                ig = pix_gap[p];
                if (ts < it)
                begin
                    // far jump back near zero: clock reset, drop later implants
                    if ((it - ts) > jump_reg && ts < low_time_reg)
                    begin
                        v.reset_seen = 1'b1;
                        for (int q = 0; q < NPIX; q++)
                        begin
                            if (pix_time[q] > ts)
                            begin
                                pix_implanted[q] = 1'b0;
                                pix_time[q] = '0;
                                pix_gap[q] = '1;
                            end
                        end
                    end
                    in_window = 1'b1;
                end
                else
                begin
                    in_window = (ts - it) < window_reg;
                end
                v.gap = ig;
                if (ig >= min_gap_reg)
                begin
                    if (in_window)
                    begin
                        v.condition = COND_VALID_DECAY;
                        v.delay = {1'b0, ts} - {1'b0, it};
                    end
                    else
                    begin
                        v.condition = COND_TOO_LATE;
                    end
                end
                else
                begin
                    v.condition = COND_TOO_SOON;
                end
            end
        end
    endtask

    // track transfers on all three ports
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t made;
        if (!rst_n)
        begin
            for (int p = 0; p < NPIX; p++)
            begin
                pix_implanted[p] = 1'b0;
                pix_time[p] = '0;
                pix_gap[p] = '1;
            end
            last_time = '0;
            any_seen = 1'b0;
            min_gap_reg = MIN_IMPLANT_GAP_RST;
            window_reg = CORRELATION_WINDOW_RST;
            jump_reg = RESET_JUMP_RST;
            low_time_reg = RESET_LOW_TIME_RST;
            pending_verdicts.delete();
            mismatch_count = 0;
            results_due = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_IMPLANT_GAP:    min_gap_reg = cfg_data;
                    CFG_CORRELATION_WINDOW: window_reg = cfg_data;
                    CFG_RESET_JUMP:         jump_reg = cfg_data;
                    CFG_RESET_LOW_TIME:     low_time_reg = cfg_data;
                    default: ;
                endcase
            end
            // result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: cond %0d delay %0d gap %h any %h reset %b",
                                 condition, decay_delay, implant_gap, gap_any_implant,
                                 clock_reset_seen);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (condition !== want.condition || decay_delay !== want.delay ||
                        implant_gap !== want.gap || gap_any_implant !== want.gap_any ||
                        clock_reset_seen !== want.reset_seen)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected cond %0d delay %0d gap %h any %h reset %b",
                                     want.condition, $signed(want.delay), want.gap,
                                     want.gap_any, want.reset_seen);
                            $display("  actual   cond %0d delay %0d gap %h any %h reset %b",
                                     condition, decay_delay, implant_gap, gap_any_implant,
                                     clock_reset_seen);
                        end
                    end
                end
            end
            // event transfer
            if (in_valid && !in_stall)
            begin
                judge_event(event_kind, front_strip, back_strip, timestamp, made);
                enqueue_verdict(made);
            end
            results_due = pending_verdicts.size();
        end
    end

endmodule

@@ tb/sv/implant_decay_pixel_correlator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implant_decay_pixel_correlator_tb
// Drives detector events into the pixel correlator in random bursts while
// the result side stalls on its own pattern. A directed set covers bad
// locations, unknown kinds, back-to-back implants, window and gap edges,
// negative delays and a clock reset; random phases then run under several
// register settings, extremes included. The checker does the comparing.
// ----------------------------------------------------------------------------
module implant_decay_pixel_correlator_tb;
    import idpc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = NPIX + 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 60;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [KIND_W-1:0]         event_kind;
    logic [STRIP_W-1:0]        front_strip;
    logic [STRIP_W-1:0]        back_strip;
    logic [TIME_W-1:0]         timestamp;
    logic                      out_valid;
    logic                      out_stall;
    logic [COND_W-1:0]         condition;
    logic signed [DELAY_W-1:0] decay_delay;
    logic [TIME_W-1:0]         implant_gap;
    logic [TIME_W-1:0]         gap_any_implant;
    logic                      clock_reset_seen;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [TIME_W-1:0]         cfg_data;

    int                        mismatch_count;
    int                        results_due;

    // sender state
    int                        burst_left;
    logic [TIME_W-1:0]         time_now;
    logic [TIME_W-1:0]         cur_low_time;

    implant_decay_pixel_correlator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .event_kind       (event_kind),
        .front_strip      (front_strip),
        .back_strip       (back_strip),
        .timestamp        (timestamp),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .condition        (condition),
        .decay_delay      (decay_delay),
        .implant_gap      (implant_gap),
        .gap_any_implant  (gap_any_implant),
        .clock_reset_seen (clock_reset_seen),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    idpc_result_checker u_result_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .event_kind       (event_kind),
        .front_strip      (front_strip),
        .back_strip       (back_strip),
        .timestamp        (timestamp),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .condition        (condition),
        .decay_delay      (decay_delay),
        .implant_gap      (implant_gap),
        .gap_any_implant  (gap_any_implant),
        .clock_reset_seen (clock_reset_seen),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .results_due      (results_due)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #50_000_000;
        $display("implant_decay_pixel_correlator_tb: done, errors");
        $finish;
    end

    // result side: stall pattern in segments, one long hold-off
    initial
    begin
        int  seg_left;
        int  mode;
        int  taken;
        bit  held;
        out_stall = 1'b0;
        seg_left = 0;
        mode = 0;
        taken = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                taken++;
            if (!held && taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // one event transfer, with a random gap at the start of each burst
    task automatic send_event(input logic [KIND_W-1:0] kind,
                              input logic [STRIP_W-1:0] fs,
                              input logic [STRIP_W-1:0] bs,
                              input logic [TIME_W-1:0] ts);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid    <= 1'b1;
        event_kind  <= kind;
        front_strip <= fs;
        back_strip  <= bs;
        timestamp   <= ts;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    // write all four registers back to back
    task automatic write_config(input logic [TIME_W-1:0] min_gap,
                                input logic [TIME_W-1:0] window,
                                input logic [TIME_W-1:0] jump,
                                input logic [TIME_W-1:0] low_time);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_IMPLANT_GAP;
        cfg_data  <= min_gap;
        @(posedge clk);
        cfg_index <= CFG_CORRELATION_WINDOW;
        cfg_data  <= window;
        @(posedge clk);
        cfg_index <= CFG_RESET_JUMP;
        cfg_data  <= jump;
        @(posedge clk);
        cfg_index <= CFG_RESET_LOW_TIME;
        cfg_data  <= low_time;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_low_time = low_time;
    endtask

    // close the open burst, wait until every result is back, let a sweep run out
    task automatic wait_for_idle();
        if (burst_left != 0)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
        @(negedge clk);
        while (results_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random events: mostly a small pixel pool on a rising time base
    task automatic run_random_phase(input int count, input int tick_shift);
        logic [KIND_W-1:0]  kind;
        logic [STRIP_W-1:0] fs;
        logic [STRIP_W-1:0] bs;
        logic [TIME_W-1:0]  ts;
        logic [TIME_W-1:0]  step;
        int                 pick;
        for (int i = 0; i < count; i++)
        begin
            // pixel
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                fs = $urandom_range(0, 3);
                bs = $urandom_range(0, 3);
            end
            else if (pick < 94)
            begin
                fs = $urandom_range(0, STRIPS - 1);
                bs = $urandom_range(0, STRIPS - 1);
            end
            else
            begin
                fs = STRIP_W'($urandom);
                bs = STRIP_W'($urandom);
            end
            // kind
            pick = $urandom_range(0, 99);
            if (pick < 46)
                kind = KIND_IMPLANT;
            else if (pick < 92)
                kind = KIND_DECAY;
            else
                kind = KIND_W'($urandom);
            // timestamp
            pick = $urandom_range(0, 99);
            step = (TIME_W'($urandom) >> $urandom_range(0, 31)) << tick_shift;
            if (pick < 75)
            begin
                time_now = time_now + step;
                ts = time_now;
            end
            else if (pick < 85)
            begin
                ts = time_now - step;
            end
            else if (pick < 90)
            begin
                ts = TIME_W'({$urandom, $urandom});
            end
            else if (pick < 94)
            begin
                time_now = time_now + TIME_W'({$urandom, $urandom} >> $urandom_range(8, 24));
                ts = time_now;
            end
            else
            begin
                // time base falls back to at most the low-time setting, as after a timestamp counter reset
                ts = TIME_W'({$urandom, $urandom} % (64'(cur_low_time) + 64'd1));
                time_now = ts;
            end
            send_event(kind, fs, bs, ts);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        event_kind  = KIND_IMPLANT;
        front_strip = '0;
        back_strip  = '0;
        timestamp   = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_MIN_IMPLANT_GAP;
        cfg_data    = '0;
        burst_left  = 0;
        time_now    = '0;
        cur_low_time = RESET_LOW_TIME_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, registers at their reset values
        send_event(KIND_IMPLANT, 6'd32, 6'd0, 48'd5);              // front strip out of range
        send_event(KIND_DECAY, 6'd0, 6'd63, 48'd5);                // back strip out of range
        send_event(KIND_OTHER, 6'd1, 6'd1, 48'd5);
        send_event(KIND_SPARE, 6'd1, 6'd1, 48'd5);
        send_event(KIND_DECAY, 6'd2, 6'd2, 48'd5);                 // decay with no implant
        send_event(KIND_IMPLANT, 6'd0, 6'd0, 48'd0);               // first implant anywhere
        send_event(KIND_IMPLANT, 6'd0, 6'd0, 48'd1000);            // back-to-back
        send_event(KIND_DECAY, 6'd0, 6'd0, 48'd2000);              // implant too soon
        send_event(KIND_IMPLANT, 6'd31, 6'd31, 48'd10_000_000);
        send_event(KIND_DECAY, 6'd31, 6'd31, 48'd10_000_100);      // valid decay
        send_event(KIND_DECAY, 6'd31, 6'd31, 48'd6_010_000_000);   // delay equals window
        send_event(KIND_DECAY, 6'd31, 6'd31, 48'd6_009_999_999);   // just inside window
        send_event(KIND_DECAY, 6'd31, 6'd31, 48'd5_000_000);       // decay before implant
        send_event(KIND_IMPLANT, 6'd5, 6'd7, 48'd0);               // time runs backward
        send_event(KIND_IMPLANT, 6'd5, 6'd7, 48'd2_000_000);
        send_event(KIND_IMPLANT, 6'd5, 6'd7, 48'd1_000_000);       // gap floors at zero
        send_event(KIND_IMPLANT, 6'd10, 6'd10, 48'hFFFF_FFFF_FFFF);
        send_event(KIND_IMPLANT, 6'd10, 6'd11, 48'd2_000_000_000_000);
        send_event(KIND_DECAY, 6'd10, 6'd10, 48'd999_999_999);     // clock reset sweep
        send_event(KIND_DECAY, 6'd10, 6'd11, 48'd0);               // cleared by the sweep
        send_event(KIND_IMPLANT, 6'd3, 6'd3, 48'd2_000_000_000_000);
        send_event(KIND_DECAY, 6'd3, 6'd3, 48'd1_000_000_000);     // not below low time
        send_event(KIND_IMPLANT, 6'd4, 6'd4, 48'd500_000_000_100);
        send_event(KIND_DECAY, 6'd4, 6'd4, 48'd100);               // jump equals threshold
        send_event(KIND_DECAY, 6'd5, 6'd7, 48'd1_100_000);         // zero gap, too soon
        wait_for_idle();

        // moderate thresholds
        write_config(48'd1 << 18, 48'd1 << 33, 48'd1 << 40, 48'd1 << 30);
        run_random_phase(250, 1);
        wait_for_idle();

        // all registers at zero
        write_config('0, '0, '0, '0);
        run_random_phase(120, 0);
        wait_for_idle();

        // all registers at full scale
        write_config('1, '1, '1, '1);
        run_random_phase(120, 8);
        wait_for_idle();

        // random thresholds
        write_config(TIME_W'({$urandom, $urandom} >> $urandom_range(24, 56)),
                     TIME_W'({$urandom, $urandom} >> $urandom_range(20, 40)),
                     TIME_W'({$urandom, $urandom} >> $urandom_range(20, 36)),
                     TIME_W'({$urandom, $urandom} >> $urandom_range(20, 40)));
        run_random_phase(300, $urandom_range(0, 10));
        wait_for_idle();

        if (mismatch_count == 0 && results_due == 0)
            $display("implant_decay_pixel_correlator_tb: done, clean");
        else
            $display("implant_decay_pixel_correlator_tb: done, errors");
        $finish;
    end

endmodule
